// ===== rtl/core/k_permutation_enumerator_assert.svh =====
// assertion macros shared by the enumerator modules
`ifndef K_PERMUTATION_ENUMERATOR_ASSERT_SVH
`define K_PERMUTATION_ENUMERATOR_ASSERT_SVH

`ifndef SYNTHESIS
`define KPE_ASSERT(name, prop, msg) \
  name: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);
`define KPE_ASSERT_ALWAYS(name, prop, msg) \
  name: assert property (@(posedge clk_i) prop) else $error(msg);
`else
`define KPE_ASSERT(name, prop, msg)
`define KPE_ASSERT_ALWAYS(name, prop, msg)
`endif

`endif

// ===== rtl/core/kpe_pkg.sv =====
package kpe_pkg;

  localparam int MAX_N     = 8;
  localparam int IDX_W     = (MAX_N > 1) ? $clog2(MAX_N) : 1;
  localparam int CNT_W     = $clog2(MAX_N + 1);
  localparam int CFG_W     = 4;
  localparam int CFG_IDX_W = 1;
  localparam int OUT_W     = 3;
  localparam int SEQ_W     = 16;

  localparam logic [CFG_IDX_W-1:0] REG_SET_SIZE   = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PICK_COUNT = 1'd1;

  localparam logic [CFG_W-1:0] SET_SIZE_RST   = 4'd8;
  localparam logic [CFG_W-1:0] PICK_COUNT_RST = 4'd3;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_START,
    OP_EMIT_RD,
    OP_EMIT_OUT,
    OP_EXH_OUT,
    OP_FLIP_INIT,
    OP_FLIP_RD,
    OP_FLIP_W1,
    OP_FLIP_W2,
    OP_SCAN_INIT,
    OP_SCAN_RD,
    OP_SCAN_DEC,
    OP_PIV,
    OP_FIND_RD,
    OP_FIND_DEC,
    OP_SWAP_W1,
    OP_SWAP_W2,
    OP_FINISH,
    OP_WRAP
  } op_e;

  typedef struct packed {
    logic done;
    logic out_free;
    logic emit_last;
    logic flip_go;
    logic a_zero;
    logic n_lt2;
    logic scan_desc;
    logic find_le;
  } sts_t;

  function automatic logic [CNT_W-1:0] eff_n(input logic [CFG_W-1:0] v);
    logic [7:0] w;
    w = 8'(v);
    if (w == 8'd0) w = 8'd1;
    if (w > 8'(MAX_N)) w = 8'(MAX_N);
    return CNT_W'(w);
  endfunction

  function automatic logic [CNT_W-1:0] eff_k(input logic [CFG_W-1:0] v,
                                             input logic [CNT_W-1:0] n);
    logic [7:0] w;
    w = 8'(v);
    if (w == 8'd0) w = 8'd1;
    if (w > 8'(n)) w = 8'(n);
    return CNT_W'(w);
  endfunction

endpackage

// ===== rtl/core/k_permutation_enumerator.sv =====
// channel | direction | handshake                | word
// in      | input     | in_valid_i / in_stall_o  | restart_i
// out     | output    | out_valid_o / out_stall_i| position_o, chosen_index_o,
//         |           |                          | sequence_number_o, last_o, exhausted_o
// cfg     | input     | cfg_valid_i / cfg_ready_o| cfg_index_i, cfg_data_i
//
// one request at a time: a start and a check step, a read and an output step per
// emitted word, then the next-permutation pass on the arrangement store (one write
// port): a read and two writes per swapped pair, a read and a compare per scanned
// or searched entry; output stalls hold the emit steps
// reset gives the identity arrangement at once through per-entry valid bits
module k_permutation_enumerator (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           in_valid_i,
  output logic                           in_stall_o,
  input  logic                           restart_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kpe_pkg::OUT_W-1:0]      position_o,
  output logic [kpe_pkg::OUT_W-1:0]      chosen_index_o,
  output logic [kpe_pkg::SEQ_W-1:0]      sequence_number_o,
  output logic                           last_o,
  output logic                           exhausted_o,
  input  logic                           cfg_valid_i,
  output logic                           cfg_ready_o,
  input  logic [kpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kpe_pkg::CFG_W-1:0]      cfg_data_i
);
  import kpe_pkg::*;

  op_e  op;
  sts_t sts;
  logic cfg_we;

  assign cfg_we = cfg_valid_i && cfg_ready_o;

  kpe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_stall_o  (in_stall_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .sts_i       (sts),
    .op_o        (op)
  );

  kpe_dpath u_dpath (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .op_i              (op),
    .sts_o             (sts),
    .restart_i         (restart_i),
    .cfg_we_i          (cfg_we),
    .cfg_index_i       (cfg_index_i),
    .cfg_data_i        (cfg_data_i),
    .out_valid_o       (out_valid_o),
    .out_stall_i       (out_stall_i),
    .position_o        (position_o),
    .chosen_index_o    (chosen_index_o),
    .sequence_number_o (sequence_number_o),
    .last_o            (last_o),
    .exhausted_o       (exhausted_o)
  );

endmodule

// ===== rtl/core/kpe_dpath.sv =====
`include "k_permutation_enumerator_assert.svh"

module kpe_dpath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  kpe_pkg::op_e                   op_i,
  output kpe_pkg::sts_t                  sts_o,
  input  logic                           restart_i,
  input  logic                           cfg_we_i,
  input  logic [kpe_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [kpe_pkg::CFG_W-1:0]      cfg_data_i,
  output logic                           out_valid_o,
  input  logic                           out_stall_i,
  output logic [kpe_pkg::OUT_W-1:0]      position_o,
  output logic [kpe_pkg::OUT_W-1:0]      chosen_index_o,
  output logic [kpe_pkg::SEQ_W-1:0]      sequence_number_o,
  output logic                           last_o,
  output logic                           exhausted_o
);
  import kpe_pkg::*;

  logic [CFG_W-1:0] set_size_q, pick_count_q;
  logic [CNT_W-1:0] n_eff, k_eff;
  logic             done_q;
  logic [SEQ_W-1:0] seq_q;
  logic [CNT_W-1:0] a_q, a_d, b_q, b_d, am1, bm1;
  logic [IDX_W-1:0] piv_q, rda_q, rdb_q;
  logic [IDX_W-1:0] mem_q [MAX_N];
  logic [MAX_N-1:0] vld_q;
  logic             rd_en_a, rd_en_b, we;
  logic [IDX_W-1:0] ra, rb, wa, wd;
  logic             clear;
  logic             out_vld_q;
  logic [OUT_W-1:0] pos_q, chosen_q;
  logic [SEQ_W-1:0] oseq_q;
  logic             last_q, exh_q;
  logic             out_free, load_out;

  assign n_eff = eff_n(set_size_q);
  assign k_eff = eff_k(pick_count_q, n_eff);
  assign am1   = a_q - 1'b1;
  assign bm1   = b_q - 1'b1;
  assign clear = cfg_we_i || (op_i == OP_START && restart_i);

  assign out_free = !out_vld_q || !out_stall_i;
  assign load_out = (op_i == OP_EMIT_OUT) || (op_i == OP_EXH_OUT);

  assign sts_o.done      = done_q;
  assign sts_o.out_free  = out_free;
  assign sts_o.emit_last = (a_q + 1'b1) == k_eff;
  assign sts_o.flip_go   = ({1'b0, a_q} + 1'b1) < {1'b0, b_q};
  assign sts_o.a_zero    = (a_q == '0);
  assign sts_o.n_lt2     = (n_eff < CNT_W'(2));
  assign sts_o.scan_desc = (rda_q >= rdb_q);
  assign sts_o.find_le   = (rdb_q <= piv_q);

  always_comb begin
    rd_en_a = 1'b0;
    rd_en_b = 1'b0;
    we      = 1'b0;
    ra      = a_q[IDX_W-1:0];
    rb      = b_q[IDX_W-1:0];
    wa      = a_q[IDX_W-1:0];
    wd      = rdb_q;
    unique case (op_i)
      OP_EMIT_RD: begin
        rd_en_a = 1'b1;
      end
      OP_FLIP_RD: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        rb      = bm1[IDX_W-1:0];
      end
      OP_SCAN_RD: begin
        rd_en_a = 1'b1;
        rd_en_b = 1'b1;
        ra      = am1[IDX_W-1:0];
        rb      = a_q[IDX_W-1:0];
      end
      OP_FIND_RD: begin
        rd_en_b = 1'b1;
      end
      OP_FLIP_W1: begin
        we = 1'b1;
      end
      OP_FLIP_W2: begin
        we = 1'b1;
        wa = bm1[IDX_W-1:0];
        wd = rda_q;
      end
      OP_SWAP_W1: begin
        we = 1'b1;
        wa = am1[IDX_W-1:0];
      end
      OP_SWAP_W2: begin
        we = 1'b1;
        wa = b_q[IDX_W-1:0];
        wd = piv_q;
      end
      default: begin
      end
    endcase
  end

  // arrangement store, entries read as identity until written
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (clear) begin
      vld_q <= '0;
    end else if (we) begin
      vld_q[wa] <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_a) rda_q <= vld_q[ra] ? mem_q[ra] : ra;
    if (rd_en_b) rdb_q <= vld_q[rb] ? mem_q[rb] : rb;
    if (op_i == OP_PIV) piv_q <= rda_q;
  end

  always_comb begin
    a_d = a_q;
    b_d = b_q;
    unique case (op_i)
      OP_START:     a_d = '0;
      OP_EMIT_OUT:  a_d = a_q + 1'b1;
      OP_FLIP_INIT: begin
        a_d = k_eff;
        b_d = n_eff;
      end
      OP_FLIP_W2: begin
        a_d = a_q + 1'b1;
        b_d = bm1;
      end
      OP_SCAN_INIT: a_d = n_eff - 1'b1;
      OP_SCAN_DEC:  a_d = am1;
      OP_PIV:       b_d = n_eff - 1'b1;
      OP_FIND_DEC:  b_d = bm1;
      OP_SWAP_W2:   b_d = n_eff;
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i) begin
    a_q <= a_d;
    b_q <= b_d;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      set_size_q   <= SET_SIZE_RST;
      pick_count_q <= PICK_COUNT_RST;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        REG_SET_SIZE:   set_size_q   <= cfg_data_i;
        REG_PICK_COUNT: pick_count_q <= cfg_data_i;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
      seq_q  <= '0;
    end else if (clear) begin
      done_q <= 1'b0;
      seq_q  <= '0;
    end else if (op_i == OP_WRAP) begin
      done_q <= 1'b1;
      seq_q  <= seq_q + 1'b1;
    end else if (op_i == OP_FINISH) begin
      seq_q <= seq_q + 1'b1;
    end
  end

  // output word register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (load_out) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (op_i == OP_EMIT_OUT) begin
      pos_q    <= OUT_W'(a_q);
      chosen_q <= OUT_W'(rda_q);
      oseq_q   <= seq_q;
      last_q   <= sts_o.emit_last;
      exh_q    <= 1'b0;
    end else if (op_i == OP_EXH_OUT) begin
      pos_q    <= '0;
      chosen_q <= '0;
      oseq_q   <= seq_q;
      last_q   <= 1'b1;
      exh_q    <= 1'b1;
    end
  end

  assign out_valid_o       = out_vld_q;
  assign position_o        = pos_q;
  assign chosen_index_o    = chosen_q;
  assign sequence_number_o = oseq_q;
  assign last_o            = last_q;
  assign exhausted_o       = exh_q;

  `KPE_ASSERT(a_cfg_restarts, cfg_we_i |=> (seq_q == '0 && !done_q), "config write did not restart")
  `KPE_ASSERT(a_wrap_sets_done, (op_i == OP_WRAP) |=> done_q, "wrap did not set exhausted")
  `KPE_ASSERT(a_exh_word, (out_vld_q && exh_q) |-> (last_q && pos_q == '0), "bad exhausted word")
  `KPE_ASSERT(a_load_when_free, load_out |-> out_free, "output word overwritten")

endmodule

// ===== rtl/core/kpe_ctrl.sv =====
`include "k_permutation_enumerator_assert.svh"

module kpe_ctrl (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          in_valid_i,
  output logic          in_stall_o,
  input  logic          cfg_valid_i,
  output logic          cfg_ready_o,
  input  kpe_pkg::sts_t sts_i,
  output kpe_pkg::op_e  op_o
);
  import kpe_pkg::*;

  typedef enum logic [16:0] {
    ST_IDLE      = 17'b00000000000000001,
    ST_CHECK     = 17'b00000000000000010,
    ST_EXH       = 17'b00000000000000100,
    ST_EMIT_RD   = 17'b00000000000001000,
    ST_EMIT      = 17'b00000000000010000,
    ST_FLIP_INIT = 17'b00000000000100000,
    ST_FLIP_RD   = 17'b00000000001000000,
    ST_FLIP_W1   = 17'b00000000010000000,
    ST_FLIP_W2   = 17'b00000000100000000,
    ST_SCAN_INIT = 17'b00000001000000000,
    ST_SCAN_RD   = 17'b00000010000000000,
    ST_SCAN_CMP  = 17'b00000100000000000,
    ST_FIND_RD   = 17'b00001000000000000,
    ST_FIND_CMP  = 17'b00010000000000000,
    ST_SWAP_W2   = 17'b00100000000000000,
    ST_FINISH    = 17'b01000000000000000,
    ST_WRAP      = 17'b10000000000000000
  } state_e;

  state_e state_q, state_d;
  logic   second_q, second_d;
  logic   idle, in_acc;

  assign idle        = (state_q == ST_IDLE);
  assign cfg_ready_o = idle;
  assign in_stall_o  = !idle || cfg_valid_i;
  assign in_acc      = in_valid_i && !in_stall_o;

  always_comb begin
    state_d  = state_q;
    second_d = second_q;
    op_o     = OP_NONE;
    unique case (state_q)
      ST_IDLE: begin
        if (in_acc) begin
          op_o    = OP_START;
          state_d = ST_CHECK;
        end
      end
      ST_CHECK: state_d = sts_i.done ? ST_EXH : ST_EMIT_RD;
      ST_EXH: begin
        if (sts_i.out_free) begin
          op_o    = OP_EXH_OUT;
          state_d = ST_IDLE;
        end
      end
      ST_EMIT_RD: begin
        op_o    = OP_EMIT_RD;
        state_d = ST_EMIT;
      end
      ST_EMIT: begin
        if (sts_i.out_free) begin
          op_o    = OP_EMIT_OUT;
          state_d = sts_i.emit_last ? ST_FLIP_INIT : ST_EMIT_RD;
        end
      end
      ST_FLIP_INIT: begin
        op_o     = OP_FLIP_INIT;
        second_d = 1'b0;
        state_d  = ST_FLIP_RD;
      end
      ST_FLIP_RD: begin
        if (sts_i.flip_go) begin
          op_o    = OP_FLIP_RD;
          state_d = ST_FLIP_W1;
        end else begin
          state_d = second_q ? ST_FINISH : ST_SCAN_INIT;
        end
      end
      ST_FLIP_W1: begin
        op_o    = OP_FLIP_W1;
        state_d = ST_FLIP_W2;
      end
      ST_FLIP_W2: begin
        op_o    = OP_FLIP_W2;
        state_d = ST_FLIP_RD;
      end
      ST_SCAN_INIT: begin
        if (sts_i.n_lt2) begin
          state_d = ST_WRAP;
        end else begin
          op_o    = OP_SCAN_INIT;
          state_d = ST_SCAN_RD;
        end
      end
      ST_SCAN_RD: begin
        if (sts_i.a_zero) begin
          state_d = ST_WRAP;
        end else begin
          op_o    = OP_SCAN_RD;
          state_d = ST_SCAN_CMP;
        end
      end
      ST_SCAN_CMP: begin
        if (sts_i.scan_desc) begin
          op_o    = OP_SCAN_DEC;
          state_d = ST_SCAN_RD;
        end else begin
          op_o    = OP_PIV;
          state_d = ST_FIND_RD;
        end
      end
      ST_FIND_RD: begin
        op_o    = OP_FIND_RD;
        state_d = ST_FIND_CMP;
      end
      ST_FIND_CMP: begin
        if (sts_i.find_le) begin
          op_o    = OP_FIND_DEC;
          state_d = ST_FIND_RD;
        end else begin
          op_o    = OP_SWAP_W1;
          state_d = ST_SWAP_W2;
        end
      end
      ST_SWAP_W2: begin
        op_o     = OP_SWAP_W2;
        second_d = 1'b1;
        state_d  = ST_FLIP_RD;
      end
      ST_FINISH: begin
        op_o    = OP_FINISH;
        state_d = ST_IDLE;
      end
      ST_WRAP: begin
        op_o    = OP_WRAP;
        state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      second_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      second_q <= second_d;
    end
  end

  `KPE_ASSERT(a_accept_to_check, in_acc |=> (state_q == ST_CHECK), "accept did not start work")
  `KPE_ASSERT(a_emit_waits, (state_q == ST_EMIT && !sts_i.out_free) |=> (state_q == ST_EMIT),
              "emit left while output busy")
  `KPE_ASSERT(a_end_to_idle, (state_q == ST_WRAP || state_q == ST_FINISH) |=> idle,
              "request did not end in idle")

endmodule

// ===== tb/sv/kpe_selection_checker.sv =====
module kpe_selection_checker (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  input  logic                          in_stall_i,
  input  logic                          restart_i,
  input  logic                          out_valid_i,
  input  logic                          out_stall_i,
  input  logic [kpe_pkg::OUT_W-1:0]     position_i,
  input  logic [kpe_pkg::OUT_W-1:0]     chosen_index_i,
  input  logic [kpe_pkg::SEQ_W-1:0]     sequence_number_i,
  input  logic                          last_i,
  input  logic                          exhausted_i,
  input  logic                          cfg_valid_i,
  input  logic                          cfg_ready_i,
  input  logic [kpe_pkg::CFG_IDX_W-1:0] cfg_index_i,
  input  logic [kpe_pkg::CFG_W-1:0]     cfg_data_i,
  output int                            fail_count_o,
  output int                            pending_o
);
  import kpe_pkg::*;

  typedef struct packed {
    logic [OUT_W-1:0] position;
    logic [OUT_W-1:0] chosen;
    logic [SEQ_W-1:0] seq;
    logic             last;
    logic             exhausted;
  } pick_t;

  pick_t            pending_picks[$];
  logic [IDX_W-1:0] order[MAX_N];
  logic             all_done;
  logic [SEQ_W-1:0] sel_count;
  logic [CFG_W-1:0] size_reg;
  logic [CFG_W-1:0] pick_reg;

  function automatic void rewind();
    for (int i = 0; i < MAX_N; i++) order[i] = IDX_W'(i);
    all_done  = 1'b0;
    sel_count = '0;
  endfunction

  function automatic void reverse_span(input int lo, input int hi);
    logic [IDX_W-1:0] t;
    while (lo + 1 < hi) begin
      t           = order[lo];
      order[lo]   = order[hi-1];
      order[hi-1] = t;
      lo++;
      hi--;
    end
  endfunction

  // lexicographic successor of order[0..n-1], 0 when it wraps to sorted
  function automatic bit step_order(input int n);
    int               i;
    int               j;
    logic [IDX_W-1:0] t;
    if (n < 2) return 1'b0;
    i = n - 1;
    while (i > 0 && order[i-1] >= order[i]) i--;
    if (i == 0) begin
      reverse_span(0, n);
      return 1'b0;
    end
    j = n - 1;
    while (order[j] <= order[i-1]) j--;
    t          = order[i-1];
    order[i-1] = order[j];
    order[j]   = t;
    reverse_span(i, n);
    return 1'b1;
  endfunction

  function automatic void emit_selection(input logic restart);
    int    n;
    int    k;
    pick_t w;
    n = int'(size_reg);
    if (n < 1) n = 1;
    if (n > MAX_N) n = MAX_N;
    k = int'(pick_reg);
    if (k < 1) k = 1;
    if (k > n) k = n;
    if (restart) rewind();
    if (all_done) begin
      w.position  = '0;
      w.chosen    = '0;
      w.seq       = sel_count;
      w.last      = 1'b1;
      w.exhausted = 1'b1;
      pending_picks.push_back(w);
      return;
    end
    for (int p = 0; p < k; p++) begin
      w.position  = OUT_W'(p);
      w.chosen    = OUT_W'(order[p]);
      w.seq       = sel_count;
      w.last      = (p + 1 == k);
      w.exhausted = 1'b0;
      pending_picks.push_back(w);
    end
    reverse_span(k, n);
    if (!step_order(n)) all_done = 1'b1;
    sel_count = sel_count + 1'b1;
  endfunction

  function automatic void check_field(input string name, input int unsigned want,
                                      input int unsigned got);
    if (want != got) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, want, got);
      fail_count_o++;
    end
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    pick_t w;
    if (!rst_ni) begin
      rewind();
      size_reg = SET_SIZE_RST;
      pick_reg = PICK_COUNT_RST;
      pending_picks.delete();
      fail_count_o = 0;
    end else begin
      if (out_valid_i && !out_stall_i) begin
        if (pending_picks.size() == 0) begin
          $display("%0t unexpected word: expected none actual pos %0d idx %0d seq %0d",
                   $time, position_i, chosen_index_i, sequence_number_i);
          fail_count_o++;
        end else begin
          w = pending_picks.pop_front();
          check_field("position", w.position, position_i);
          check_field("chosen_index", w.chosen, chosen_index_i);
          check_field("sequence_number", w.seq, sequence_number_i);
          check_field("last", w.last, last_i);
          check_field("exhausted", w.exhausted, exhausted_i);
        end
      end
      if (cfg_valid_i && cfg_ready_i) begin
        case (cfg_index_i)
          REG_SET_SIZE: begin
            size_reg = cfg_data_i;
            rewind();
          end
          REG_PICK_COUNT: begin
            pick_reg = cfg_data_i;
            rewind();
          end
          default: ;
        endcase
      end
      if (in_valid_i && !in_stall_i) emit_selection(restart_i);
    end
    pending_o = pending_picks.size();
  end

endmodule

// ===== tb/sv/k_permutation_enumerator_tb.sv =====
module k_permutation_enumerator_tb;
  import kpe_pkg::*;

  localparam int SETTLE_CYCLES = 120;
  localparam int QUIET_LIMIT   = 4000;
  localparam int RANDOM_ITEMS  = 80;

  logic                 clk         = 1'b0;
  logic                 rst_n       = 1'b0;
  logic                 in_valid    = 1'b0;
  logic                 in_stall;
  logic                 restart     = 1'b0;
  logic                 out_valid;
  logic                 out_stall   = 1'b0;
  logic [OUT_W-1:0]     position;
  logic [OUT_W-1:0]     chosen_index;
  logic [SEQ_W-1:0]     sequence_number;
  logic                 last;
  logic                 exhausted;
  logic                 cfg_valid   = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index   = '0;
  logic [CFG_W-1:0]     cfg_data    = '0;

  int fail_count;
  int pending;
  int gap_pct     = 20;
  int stall_pct   = 20;
  int stall_left  = 0;
  int quiet_count = 0;

  always #5 clk = ~clk;

  k_permutation_enumerator dut (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_o        (in_stall),
    .restart_i         (restart),
    .out_valid_o       (out_valid),
    .out_stall_i       (out_stall),
    .position_o        (position),
    .chosen_index_o    (chosen_index),
    .sequence_number_o (sequence_number),
    .last_o            (last),
    .exhausted_o       (exhausted),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_o       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data)
  );

  kpe_selection_checker checker_i (
    .clk_i             (clk),
    .rst_ni            (rst_n),
    .in_valid_i        (in_valid),
    .in_stall_i        (in_stall),
    .restart_i         (restart),
    .out_valid_i       (out_valid),
    .out_stall_i       (out_stall),
    .position_i        (position),
    .chosen_index_i    (chosen_index),
    .sequence_number_i (sequence_number),
    .last_i            (last),
    .exhausted_i       (exhausted),
    .cfg_valid_i       (cfg_valid),
    .cfg_ready_i       (cfg_ready),
    .cfg_index_i       (cfg_index),
    .cfg_data_i        (cfg_data),
    .fail_count_o      (fail_count),
    .pending_o         (pending)
  );

  // receiver back-pressure in random bursts
  always @(negedge clk) begin
    if (stall_left > 0) begin
      out_stall  <= 1'b1;
      stall_left <= stall_left - 1;
    end else begin
      out_stall <= 1'b0;
      if ($urandom_range(0, 99) < stall_pct) stall_left <= $urandom_range(1, 11);
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) ||
        (cfg_valid && cfg_ready)) begin
      quiet_count <= 0;
    end else begin
      quiet_count <= quiet_count + 1;
    end
  end

  initial begin
    while (quiet_count < QUIET_LIMIT) @(posedge clk);
    $display("*** FAILED ***");
    $finish;
  end

  task automatic send_word(input logic rs);
    int gap;
    @(negedge clk);
    if ($urandom_range(0, 99) < gap_pct) begin
      gap = $urandom_range(1, 11);
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    restart  <= rs;
    do @(posedge clk); while (in_stall);
  endtask

  // hold off until every word is back and the permutation pass is over
  task automatic settle();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic configure(input logic [CFG_W-1:0] size, input logic [CFG_W-1:0] picks);
    settle();
    if ($urandom_range(0, 1) == 0) begin
      write_reg(REG_SET_SIZE, size);
      write_reg(REG_PICK_COUNT, picks);
    end else begin
      write_reg(REG_PICK_COUNT, picks);
      write_reg(REG_SET_SIZE, size);
    end
  endtask

  function automatic int idle_rate();
    case ($urandom_range(0, 2))
      0:       return 0;
      1:       return 10;
      default: return 35;
    endcase
  endfunction

  initial begin
    int               sent;
    int               burst;
    logic [CFG_W-1:0] size;
    logic [CFG_W-1:0] picks;
    sent = 0;
    repeat (9) @(negedge clk);
    rst_n <= 1'b1;

    // reset defaults
    send_word(1'b0);
    send_word(1'b0);
    send_word(1'b1);
    // full enumeration of 3 out of 3, then exhausted requests and a restart
    configure(4'd3, 4'd3);
    repeat (8) send_word(1'b0);
    send_word(1'b1);
    send_word(1'b0);
    // zero registers behave as one
    configure(4'd0, 4'd0);
    repeat (2) send_word(1'b0);
    // saturated set size, pick count clamped to it
    configure(4'd15, 4'd15);
    repeat (2) send_word(1'b0);
    configure(4'd4, 4'd9);
    repeat (2) send_word(1'b0);
    configure(4'd8, 4'd1);
    send_word(1'b0);

    while (sent < RANDOM_ITEMS) begin
      if (sent >= RANDOM_ITEMS - 20) begin
        gap_pct   = 0;
        stall_pct = 0;
      end else begin
        gap_pct   = idle_rate();
        stall_pct = idle_rate();
      end
      if ($urandom_range(0, 9) < 7) size = CFG_W'($urandom_range(1, 5));
      else size = CFG_W'($urandom_range(0, 15));
      if ($urandom_range(0, 9) < 7) picks = CFG_W'($urandom_range(1, 4));
      else picks = CFG_W'($urandom_range(0, 15));
      configure(size, picks);
      burst = $urandom_range(3, 16);
      for (int i = 0; i < burst && sent < RANDOM_ITEMS; i++) begin
        send_word($urandom_range(0, 9) == 0);
        sent++;
      end
    end

    settle();
    if (fail_count == 0 && pending == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl/core
rtl/core/kpe_pkg.sv
rtl/core/kpe_dpath.sv
rtl/core/kpe_ctrl.sv
rtl/core/k_permutation_enumerator.sv
tb/sv/kpe_selection_checker.sv
tb/sv/k_permutation_enumerator_tb.sv
